/* hw/rtl/owb_pkg.sv */
// types and constants shared by the serial to one-wire bridge command interpreter
// no dependencies; used by owb_front, owb_queue, owb_back and the top level

package owb_pkg;

  typedef enum logic [1:0] {
    MODE_INACTIVE,
    MODE_CMD,
    MODE_XFER,
    MODE_ESC
  } mode_t;

  localparam logic [1:0] BUS_NONE  = 2'd0;
  localparam logic [1:0] BUS_RESET = 2'd1;
  localparam logic [1:0] BUS_WBIT  = 2'd2;
  localparam logic [1:0] BUS_WBYTE = 2'd3;

  localparam logic [2:0] CMD_BIT   = 3'd4;
  localparam logic [2:0] CMD_ACCEL = 3'd5;
  localparam logic [2:0] CMD_RESET = 3'd6;
  localparam logic [2:0] CMD_PULSE = 3'd7;

  localparam logic [7:0] BYTE_DATA_MODE = 8'hE1;
  localparam logic [7:0] BYTE_ESCAPE    = 8'hE3;
  localparam logic [7:0] CAL_MASK       = 8'hE3;
  localparam logic [7:0] CAL_MATCH      = 8'hC1;
  localparam logic [7:0] REPLY_RESET    = 8'hCD;
  localparam logic [7:0] REPLY_PARAM0   = 8'hFE;
  localparam logic [2:0] CODE_BAUD      = 3'd7;
  localparam logic [2:0] BAUD_MAX       = 3'd3;

  localparam int NUM_PARAMS = 7;

  typedef logic [NUM_PARAMS-1:0][2:0] param_arr_t;

  // entry 0 is parameter 1
  localparam param_arr_t PARAM_DEFAULTS = {3'd0, 3'd6, 3'd5, 3'd0, 3'd4, 3'd4, 3'd0};

  typedef struct packed {
    logic [7:0] host_byte;
    logic       bus_bit;
    logic [7:0] bus_byte;
    logic       cal_ok;
    logic       odd;
    logic       is_data_mode;
    logic       is_escape;
    logic       is_cfg;
    logic [2:0] cmd_op;
    logic [1:0] speed;
    logic [2:0] cfg_code;
    logic [2:0] cfg_val;
  } class_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic [1:0] bus_op;
    logic       bus_bit_out;
    logic [7:0] bus_byte_out;
    logic [1:0] bus_speed;
    logic       error_flag;
  } res_t;

endpackage

/* hw/rtl/serial_onewire_bridge_command_mode_top.sv */
// top level of the serial to one-wire bridge command interpreter
// depends on owb_pkg, owb_front, owb_queue, owb_back
//
//   channel | handshake           | payload
//   in      | in_valid / in_stall   | host_byte, bus_bit_in, bus_byte_in
//   out     | out_valid / out_stall | reply_valid, reply_byte, bus_op, bus_bit_out,
//           |                       | bus_byte_out, bus_speed, error_flag
//
// one transfer in and one out per cycle when neither side stalls
// each transfer passes through the queue and then the back-end output register
// in_stall rises only when the queue holds QUEUE_DEPTH entries
// rst clears mode, speed, accelerator flag, queue and output valid, and loads the parameter defaults

module serial_onewire_bridge_command_mode_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] host_byte,
  input  logic       bus_bit_in,
  input  logic [7:0] bus_byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       reply_valid,
  output logic [7:0] reply_byte,
  output logic [1:0] bus_op,
  output logic       bus_bit_out,
  output logic [7:0] bus_byte_out,
  output logic [1:0] bus_speed,
  output logic       error_flag
);

  owb_pkg::class_t entry;
  owb_pkg::class_t head;
  owb_pkg::res_t   result;
  logic            full;
  logic            empty;
  logic            pop;
  logic            push;

  assign in_stall = full;
  assign push     = in_valid & ~full;

  owb_front u_front (
    .host_byte   (host_byte),
    .bus_bit_in  (bus_bit_in),
    .bus_byte_in (bus_byte_in),
    .entry       (entry)
  );

  owb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  owb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_ok   (~empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
  );

  assign reply_valid  = result.reply_valid;
  assign reply_byte   = result.reply_byte;
  assign bus_op       = result.bus_op;
  assign bus_bit_out  = result.bus_bit_out;
  assign bus_byte_out = result.bus_byte_out;
  assign bus_speed    = result.bus_speed;
  assign error_flag   = result.error_flag;

endmodule

/* hw/rtl/owb_front.sv */
// front end: decodes one host byte into a classified entry for the queue
// depends on owb_pkg

module owb_front (
  input  logic [7:0]      host_byte,
  input  logic            bus_bit_in,
  input  logic [7:0]      bus_byte_in,
  output owb_pkg::class_t entry
);

  logic [1:0] raw_speed;

  assign raw_speed = host_byte[3:2];

  always_comb begin
    entry.host_byte    = host_byte;
    entry.bus_bit      = bus_bit_in;
    entry.bus_byte     = bus_byte_in;
    entry.cal_ok       = (host_byte & owb_pkg::CAL_MASK) == owb_pkg::CAL_MATCH;
    entry.odd          = host_byte[0];
    entry.is_data_mode = host_byte == owb_pkg::BYTE_DATA_MODE;
    entry.is_escape    = host_byte == owb_pkg::BYTE_ESCAPE;
    entry.is_cfg       = ~host_byte[7];
    entry.cmd_op       = host_byte[7:5];
    // speed code 3 maps to regular
    entry.speed        = (raw_speed == 2'd3) ? 2'd0 : raw_speed;
    entry.cfg_code     = host_byte[6:4];
    entry.cfg_val      = host_byte[3:1];
  end

endmodule

/* hw/rtl/owb_queue.sv */
// short queue of classified entries between front and back ends
// depends on owb_pkg

module owb_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  owb_pkg::class_t push_entry,
  input  logic            pop,
  output owb_pkg::class_t head,
  output logic            full,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  owb_pkg::class_t    slots [DEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [CW-1:0]      count;

  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/owb_back.sv */
// back end: runs queued entries against mode, speed, accelerator and parameter state
// and holds the result in an output register; depends on owb_pkg

module owb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_ok,
  input  owb_pkg::class_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output owb_pkg::res_t   result
);

  owb_pkg::mode_t     mode;
  owb_pkg::mode_t     mode_next;
  logic [1:0]         speed;
  logic [1:0]         speed_next;
  logic               accel;
  logic               accel_next;
  owb_pkg::param_arr_t params;
  owb_pkg::param_arr_t params_next;
  owb_pkg::res_t      res;
  logic               do_cmd;
  logic               do_data;
  logic [2:0]         rd_idx;
  logic [2:0]         wr_idx;

  assign pop    = head_ok & (~out_valid | ~out_stall);
  assign rd_idx = head.cfg_val - 3'd1;
  assign wr_idx = head.cfg_code - 3'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= owb_pkg::MODE_INACTIVE;
      speed     <= 2'd0;
      accel     <= 1'b0;
      params    <= owb_pkg::PARAM_DEFAULTS;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        mode   <= mode_next;
        speed  <= speed_next;
        accel  <= accel_next;
        params <= params_next;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= res;
    end
  end

  always_comb begin
    mode_next   = mode;
    speed_next  = speed;
    accel_next  = accel;
    params_next = params;
    do_cmd      = 1'b0;
    do_data     = 1'b0;
    res         = '0;

    case (mode)
      owb_pkg::MODE_INACTIVE: begin
        if (head.cal_ok) begin
          mode_next = owb_pkg::MODE_CMD;
        end else begin
          res.error_flag = 1'b1;
        end
      end
      owb_pkg::MODE_CMD: begin
        do_cmd = 1'b1;
      end
      owb_pkg::MODE_XFER: begin
        if (head.is_escape) begin
          mode_next = owb_pkg::MODE_ESC;
        end else begin
          do_data = 1'b1;
        end
      end
      owb_pkg::MODE_ESC: begin
        if (head.is_escape) begin
          mode_next = owb_pkg::MODE_XFER;
          do_data   = 1'b1;
        end else begin
          mode_next = owb_pkg::MODE_CMD;
          do_cmd    = 1'b1;
        end
      end
      default: begin
        mode_next = owb_pkg::MODE_INACTIVE;
      end
    endcase

    if (do_data) begin
      if (accel) begin
        res.error_flag = 1'b1;
        mode_next      = owb_pkg::MODE_INACTIVE;
      end else begin
        res.bus_op       = owb_pkg::BUS_WBYTE;
        res.bus_byte_out = head.host_byte;
        res.reply_valid  = 1'b1;
        res.reply_byte   = head.bus_byte;
      end
    end

    if (do_cmd) begin
      if (~head.odd) begin
        res.error_flag = 1'b1;
        mode_next      = owb_pkg::MODE_INACTIVE;
      end else if (head.is_data_mode) begin
        mode_next = owb_pkg::MODE_XFER;
      end else if (head.is_cfg) begin
        res.reply_valid = 1'b1;
        if (head.cfg_code == 3'd0) begin
          if (head.cfg_val == 3'd0) begin
            res.reply_byte = owb_pkg::REPLY_PARAM0;
          end else begin
            res.reply_byte = {4'd0, params[rd_idx], 1'b0};
          end
        end else begin
          // baud rate above the top code is not stored
          if (!(head.cfg_code == owb_pkg::CODE_BAUD && head.cfg_val > owb_pkg::BAUD_MAX)) begin
            params_next[wr_idx] = head.cfg_val;
          end
          res.reply_byte = {head.host_byte[7:1], 1'b0};
        end
      end else begin
        case (head.cmd_op)
          owb_pkg::CMD_BIT: begin
            speed_next      = head.speed;
            res.bus_op      = owb_pkg::BUS_WBIT;
            res.bus_bit_out = head.host_byte[4];
            res.reply_valid = 1'b1;
            res.reply_byte  = {head.host_byte[7:2], head.bus_bit, head.bus_bit};
          end
          owb_pkg::CMD_ACCEL: begin
            accel_next = head.host_byte[4];
            speed_next = head.speed;
          end
          owb_pkg::CMD_RESET: begin
            speed_next      = head.speed;
            params_next     = owb_pkg::PARAM_DEFAULTS;
            mode_next       = owb_pkg::MODE_CMD;
            res.bus_op      = owb_pkg::BUS_RESET;
            res.reply_valid = 1'b1;
            res.reply_byte  = owb_pkg::REPLY_RESET;
          end
          owb_pkg::CMD_PULSE: begin
            res.error_flag = 1'b1;
            mode_next      = owb_pkg::MODE_INACTIVE;
          end
          default: begin
            res.error_flag = 1'b1;
            mode_next      = owb_pkg::MODE_INACTIVE;
          end
        endcase
      end
    end

    res.bus_speed = speed_next;
  end

endmodule

/* hw/rtl/owb_checker.sv */
// port-level checks for the bridge command interpreter, bound to the top level
// depends on owb_pkg and serial_onewire_bridge_command_mode_top

module owb_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic       reply_valid,
  input logic [7:0] reply_byte,
  input logic [1:0] bus_op,
  input logic       bus_bit_out,
  input logic [7:0] bus_byte_out,
  input logic [1:0] bus_speed,
  input logic       error_flag
);

  // a stalled result stays valid and holds its reply byte, bus op, error flag and speed
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reply_byte) && $stable(bus_op)
      && $stable(error_flag) && $stable(bus_speed))
    else $error("stalled result changed");

  a_reply_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reply_valid |-> reply_byte == 8'd0)
    else $error("reply byte set without reply");

  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_flag |-> !reply_valid && bus_op == owb_pkg::BUS_NONE)
    else $error("error with reply or bus action");

  a_bus_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bus_op == owb_pkg::BUS_WBIT || !bus_bit_out)
      && (bus_op == owb_pkg::BUS_WBYTE || bus_byte_out == 8'd0))
    else $error("bus data without matching action");

  a_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bus_speed != 2'd3)
    else $error("speed code 3 reported");

endmodule

bind serial_onewire_bridge_command_mode_top owb_checker u_chk (.*);

/* bench/serial_onewire_bridge_command_mode_top_tb.sv */
// testbench for serial_onewire_bridge_command_mode_top: directed and random host byte streams,
// checked one transfer at a time against a behavioral decoder held here
// depends on owb_pkg and the top level rtl

module serial_onewire_bridge_command_mode_top_tb;
  import owb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [7:0] hb;
    logic       bit_in;
    logic [7:0] byte_in;
    int         gap;
    bit         drain;
  } host_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] host_byte = 8'd0;
  logic       bus_bit_in = 1'b0;
  logic [7:0] bus_byte_in = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       reply_valid;
  logic [7:0] reply_byte;
  logic [1:0] bus_op;
  logic       bus_bit_out;
  logic [7:0] bus_byte_out;
  logic [1:0] bus_speed;
  logic       error_flag;

  host_item_t host_stream[$];
  res_t       expected_replies[$];

  int bytes_sent = 0;
  int replies_checked = 0;
  int results_seen = 0;
  int mismatches = 0;
  int errors_seen = 0;
  int replies_seen = 0;
  int stall_cycles = 0;
  int idle_cnt = 0;
  int rx_hold = 0;
  int cycles = 0;

  // decoder state
  mode_t      pm_mode;
  logic [1:0] pm_speed;
  logic       pm_accel;
  param_arr_t pm_param;

  serial_onewire_bridge_command_mode_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .host_byte(host_byte), .bus_bit_in(bus_bit_in), .bus_byte_in(bus_byte_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .reply_valid(reply_valid), .reply_byte(reply_byte), .bus_op(bus_op),
    .bus_bit_out(bus_bit_out), .bus_byte_out(bus_byte_out),
    .bus_speed(bus_speed), .error_flag(error_flag)
  );

  always #2 clk = ~clk;

  function automatic logic [1:0] speed_of(logic [7:0] b);
    return (b[3:2] == 2'd3) ? 2'd0 : b[3:2];
  endfunction

  function automatic res_t drop_to_inactive();
    res_t r;
    r = '0;
    r.error_flag = 1'b1;
    pm_mode = MODE_INACTIVE;
    return r;
  endfunction

  function automatic res_t write_bus_byte(logic [7:0] b, logic [7:0] readback);
    res_t r;
    if (pm_accel) return drop_to_inactive();
    r = '0;
    r.bus_op = BUS_WBYTE;
    r.bus_byte_out = b;
    r.reply_valid = 1'b1;
    r.reply_byte = readback;
    return r;
  endfunction

  function automatic res_t run_host_command(logic [7:0] b, logic bit_in);
    res_t       r;
    logic [2:0] code;
    logic [2:0] val;
    r = '0;
    code = b[6:4];
    val = b[3:1];
    if (!b[0]) return drop_to_inactive();
    if (b == BYTE_DATA_MODE) begin
      pm_mode = MODE_XFER;
      return r;
    end
    if (!b[7]) begin
      r.reply_valid = 1'b1;
      if (code == 3'd0) begin
        r.reply_byte = (val == 3'd0) ? REPLY_PARAM0 : {4'd0, pm_param[int'(val) - 1], 1'b0};
      end else begin
        if (!(code == CODE_BAUD && val > BAUD_MAX)) pm_param[int'(code) - 1] = val;
        r.reply_byte = {b[7:1], 1'b0};
      end
      return r;
    end
    case (b[7:5])
      CMD_BIT: begin
        pm_speed = speed_of(b);
        r.bus_op = BUS_WBIT;
        r.bus_bit_out = b[4];
        r.reply_valid = 1'b1;
        r.reply_byte = {b[7:2], bit_in, bit_in};
      end
      CMD_ACCEL: begin
        pm_accel = b[4];
        pm_speed = speed_of(b);
      end
      CMD_RESET: begin
        pm_speed = speed_of(b);
        pm_param = PARAM_DEFAULTS;
        pm_mode = MODE_CMD;
        r.bus_op = BUS_RESET;
        r.reply_valid = 1'b1;
        r.reply_byte = REPLY_RESET;
      end
      default: r = drop_to_inactive();
    endcase
    return r;
  endfunction

  function automatic res_t decode_host_byte(logic [7:0] b, logic bit_in, logic [7:0] byte_in);
    res_t r;
    r = '0;
    case (pm_mode)
      MODE_INACTIVE: begin
        if ((b & CAL_MASK) == CAL_MATCH) pm_mode = MODE_CMD;
        else r.error_flag = 1'b1;
      end
      MODE_CMD: r = run_host_command(b, bit_in);
      MODE_XFER: begin
        if (b == BYTE_ESCAPE) pm_mode = MODE_ESC;
        else r = write_bus_byte(b, byte_in);
      end
      default: begin
        if (b == BYTE_ESCAPE) begin
          pm_mode = MODE_XFER;
          r = write_bus_byte(b, byte_in);
        end else begin
          pm_mode = MODE_CMD;
          r = run_host_command(b, bit_in);
        end
      end
    endcase
    r.bus_speed = pm_speed;
    return r;
  endfunction

  function automatic logic [7:0] cfg_byte(logic [2:0] code, logic [2:0] val);
    return {1'b0, code, val, 1'b1};
  endfunction

  // bit1 is don't-care for these commands, so it is drawn at random
  function automatic logic [7:0] cmd_byte(logic [2:0] op, logic b4, logic [1:0] spd);
    return {op, b4, spd, 1'($urandom_range(0, 1)), 1'b1};
  endfunction

  task automatic queue_byte(input logic [7:0] b);
    host_item_t it;
    it.hb = b;
    it.bit_in = 1'($urandom_range(0, 1));
    it.byte_in = 8'($urandom);
    it.gap = ((host_stream.size() / 120) % 4 == 2) ? 0 : $urandom_range(0, 15);
    it.drain = (host_stream.size() % 400 == 399);
    host_stream.push_back(it);
  endtask

  task automatic queue_random_command();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) queue_byte(cfg_byte(3'($urandom), 3'($urandom)));
    else if (k < 8) queue_byte(cmd_byte(CMD_BIT, 1'($urandom), 2'($urandom)));
    else if (k < 9) queue_byte(cmd_byte(CMD_ACCEL, $urandom_range(0, 3) == 0, 2'($urandom)));
    else queue_byte(cmd_byte(CMD_RESET, 1'($urandom), 2'($urandom)));
  endtask

  task automatic queue_data_burst();
    logic [7:0] d;
    queue_byte(BYTE_DATA_MODE);
    repeat ($urandom_range(1, 10)) begin
      d = ($urandom_range(0, 7) == 0) ? BYTE_ESCAPE : 8'($urandom);
      queue_byte(d);
      if (d == BYTE_ESCAPE) queue_byte(BYTE_ESCAPE);
    end
    queue_byte(BYTE_ESCAPE);
    queue_random_command();
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0h, got %0h", results_seen, name, want, got);
    end
  endtask

  // driver
  always @(posedge clk) begin
    host_item_t it;
    bit         took;
    if (rst) begin
      in_valid <= 1'b0;
      idle_cnt = 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        expected_replies.push_back(decode_host_byte(host_byte, bus_bit_in, bus_byte_in));
        bytes_sent <= bytes_sent + 1;
      end
      if (in_valid && in_stall) stall_cycles++;
      if (!in_valid || took) begin
        if (host_stream.size() == 0) begin
          in_valid <= 1'b0;
        end else if (host_stream[0].drain && replies_checked != bytes_sent + int'(took)) begin
          in_valid <= 1'b0;
        end else if (idle_cnt < host_stream[0].gap) begin
          idle_cnt++;
          in_valid <= 1'b0;
        end else begin
          it = host_stream.pop_front();
          host_byte <= it.hb;
          bus_bit_in <= it.bit_in;
          bus_byte_in <= it.byte_in;
          in_valid <= 1'b1;
          idle_cnt = 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      out_stall <= 1'b0;
      rx_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {reply_valid, reply_byte, bus_op, bus_bit_out, bus_byte_out, bus_speed,
               error_flag};
        results_seen++;
        if (got.error_flag) errors_seen++;
        if (got.reply_valid) replies_seen++;
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result %0d: transfer with nothing expected",
                                         results_seen);
        end else begin
          want = expected_replies.pop_front();
          check_field("reply_valid", want.reply_valid, got.reply_valid);
          check_field("reply_byte", want.reply_byte, got.reply_byte);
          check_field("bus_op", want.bus_op, got.bus_op);
          check_field("bus_bit_out", want.bus_bit_out, got.bus_bit_out);
          check_field("bus_byte_out", want.bus_byte_out, got.bus_byte_out);
          check_field("bus_speed", want.bus_speed, got.bus_speed);
          check_field("error_flag", want.error_flag, got.error_flag);
          replies_checked <= replies_checked + 1;
        end
        // one long hold so the queue fills and the input side stalls
        if (results_seen == 500) rx_hold = 200;
        else if ((results_seen / 150) % 3 == 1) rx_hold = 0;
        else rx_hold = $urandom_range(0, 15);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      out_stall <= (rx_hold > 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("serial_onewire_bridge_command_mode_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    pm_mode = MODE_INACTIVE;
    pm_speed = 2'd0;
    pm_accel = 1'b0;
    pm_param = PARAM_DEFAULTS;

    // directed
    queue_byte(8'h00);
    queue_byte(CAL_MATCH);
    queue_byte(cfg_byte(3'd0, 3'd0));
    queue_byte(cfg_byte(3'd0, 3'd1));
    queue_byte(cfg_byte(CODE_BAUD, 3'd7));
    queue_byte(cfg_byte(3'd0, 3'd7));
    queue_byte(cfg_byte(CODE_BAUD, 3'd2));
    queue_byte(cfg_byte(3'd0, 3'd7));
    queue_byte(cfg_byte(3'd1, 3'd0));
    queue_byte(cmd_byte(CMD_BIT, 1'b1, 2'd3));
    queue_byte(cmd_byte(CMD_BIT, 1'b0, 2'd1));
    queue_byte(cmd_byte(CMD_ACCEL, 1'b1, 2'd2));
    queue_byte(BYTE_DATA_MODE);
    queue_byte(8'h55);
    queue_byte(CAL_MATCH | 8'h1C);
    queue_byte(cmd_byte(CMD_ACCEL, 1'b0, 2'd0));
    queue_byte(BYTE_DATA_MODE);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(BYTE_ESCAPE);
    queue_byte(BYTE_ESCAPE);
    queue_byte(BYTE_ESCAPE);
    queue_byte(cmd_byte(CMD_RESET, 1'b0, 2'd0));
    queue_byte(8'h80);
    queue_byte(CAL_MATCH);
    queue_byte(cmd_byte(CMD_PULSE, 1'b1, 2'd3));
    queue_byte(CAL_MATCH);
    queue_byte(cmd_byte(CMD_RESET, 1'b0, 2'd2));
    queue_byte(8'h70);

    // random: calibrated sequences of legal commands and data bursts, with some noise and pulses
    while (host_stream.size() < 1630) begin
      queue_byte(CAL_MATCH | {3'd0, 3'($urandom), 2'd0});
      repeat ($urandom_range(1, 12)) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: queue_random_command();
          10, 11, 12, 13, 14, 15, 16: queue_data_burst();
          17: queue_byte(cmd_byte(CMD_PULSE, 1'($urandom), 2'($urandom)));
          default: queue_byte(8'($urandom));
        endcase
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (host_stream.size() > 0 || in_valid) @(posedge clk);
    while (replies_checked != bytes_sent) @(posedge clk);
    repeat (10) @(posedge clk);
    mismatches += expected_replies.size();

    $display("%0d host bytes sent, %0d results checked (%0d replies, %0d error flags)",
             bytes_sent, results_seen, replies_seen, errors_seen);
    $display("%0d cycles with input stalled, %0d mismatches", stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("serial_onewire_bridge_command_mode_top_tb OK");
    end else begin
      $display("serial_onewire_bridge_command_mode_top_tb NOT OK");
    end
    $finish;
  end

endmodule
